### hw/rtl/rmq_pkg.sv
// Shared types, constants and the square-root step of the matrix-to-quaternion block.
package rmq_pkg;

  // Fixed-point format of matrix elements and quaternion components
  localparam int FRAC_BITS = 30;
  localparam int TOL_W     = 30;
  localparam logic [TOL_W-1:0] TOL_RESET = 30'd107;

  // Quotient bits kept by a divider; results clamp at 2^(Q_W-1)
  localparam int Q_W  = 41;
  // Root bits of the component root and of the norm root
  localparam int C_W  = 31;
  localparam int RT_W = 42;
  // Radicand / remainder width of the shared root step
  localparam int SR_W = 84;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic               renormalized;
    logic               bad_matrix;
  } out_beat_t;

  // Partial root and remainder (radicand minus root squared)
  typedef struct packed {
    logic [RT_W-1:0] root;
    logic [SR_W-1:0] rem;
  } sqs_t;

  // One restoring square-root step: try to set root bit b
  function automatic sqs_t sqrt_step(input sqs_t st, input int b);
    sqs_t            nx;
    logic [SR_W-1:0] trial;
    nx    = st;
    trial = (SR_W'(st.root) << (b + 1)) + (SR_W'(1) << (2 * b));
    if (st.rem >= trial) begin
      nx.rem  = st.rem - trial;
      nx.root = st.root | (RT_W'(1) << b);
    end
    return nx;
  endfunction

endpackage

### hw/rtl/rotation_matrix_to_quaternion.sv
// Top level: pipelined rotation-matrix to unit-quaternion converter (Shepperd's method).
//
// Input channel: a matrix beat (nine signed Q2.30 elements in in_data) is taken at
// each rising edge with start high and busy low. busy stays low: the pipeline takes
// one beat every cycle, back to back, with no bubbles.
// Result channel: out_strobe is high for one cycle with the quaternion and its two
// flags on out_data. The receiver cannot stall, so nothing is held back.
// Throughput: one beat per cycle.
// The depth is set by the two bit-per-stage root pipelines (31 and 42 stages) and
// the two banks of bit-per-stage dividers (42 stages each), plus eight stages for
// the diagonal sums, the largest-sum pick, the signed components, the partial
// products, the squares, the pair sums, the norm sum and the output.
// Configuration: cfg_we writes cfg_wdata into the norm tolerance (units 2^-30);
// write it only while no beat is in flight.
// Reset (rst_n low, synchronous) clears all beat valids and sets the tolerance to
// 107; beats in flight at reset are dropped.
module rotation_matrix_to_quaternion (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rmq_pkg::in_beat_t             in_data,
  output logic                          out_strobe,
  output rmq_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [rmq_pkg::TOL_W-1:0]     cfg_wdata
);

  localparam int F       = rmq_pkg::FRAC_BITS;
  localparam int Q_W     = rmq_pkg::Q_W;
  localparam int C_W     = rmq_pkg::C_W;
  localparam int RT_W    = rmq_pkg::RT_W;
  localparam int SR_W    = rmq_pkg::SR_W;
  localparam int S_W     = 34;              // diagonal sums
  localparam int D_W     = 33;              // off-diagonal sums
  localparam int P_W     = 42;              // signed components before saturation
  localparam int M_W     = 41;              // component magnitudes
  localparam int L_W     = 21;              // low part of a magnitude split
  localparam int H_W     = M_W - L_W;
  localparam int SQ_W    = 83;              // squares and their sum
  localparam int V_W     = P_W + 1;
  localparam int DIV_LAT = Q_W + 1;
  localparam int PD_LEN  = 4 + RT_W;        // components held from squaring to the norm
  localparam int LAT     = C_W + RT_W + 2 * DIV_LAT + 8;

  localparam logic signed [S_W-1:0] ONE_S = S_W'(1) << F;
  localparam logic [RT_W-1:0]       ONE_N = RT_W'(1) << F;
  localparam logic signed [V_W-1:0] MAXV  = V_W'(32'h7fffffff);
  localparam logic signed [V_W-1:0] MINV  = -MAXV - V_W'(1);

  typedef struct packed {
    logic [1:0]            k;
    logic                  bad;
    logic [3:0][D_W-1:0]   d;
  } side1_t;

  typedef struct packed {
    logic [C_W-1:0]        c;
    logic [1:0]            k;
    logic                  bad;
    logic [3:0]            dneg;
  } side2_t;

  typedef struct packed {
    logic [3:0][P_W-1:0]   p;
    logic                  bad;
  } pside_t;

  typedef struct packed {
    logic [3:0][P_W-1:0]   p;
    logic                  renorm;
    logic                  flip;
    logic                  bad;
  } side4_t;

  logic [rmq_pkg::TOL_W-1:0] tol_r;
  logic [LAT-1:0]            vld_r;

  assign busy = 1'b0;

  // Tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= rmq_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // Beat valids travel down the whole pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // Stage A: diagonal sums and off-diagonal sums / differences
  logic signed [S_W-1:0] a_s_r [4];
  logic signed [D_W-1:0] a_sum01_r, a_sum02_r, a_sum12_r;
  logic signed [D_W-1:0] a_dif12_r, a_dif20_r, a_dif01_r;

  always_ff @(posedge clk) begin
    a_s_r[0]  <= ONE_S + S_W'(in_data.m00) - S_W'(in_data.m11) - S_W'(in_data.m22);
    a_s_r[1]  <= ONE_S - S_W'(in_data.m00) + S_W'(in_data.m11) - S_W'(in_data.m22);
    a_s_r[2]  <= ONE_S - S_W'(in_data.m00) - S_W'(in_data.m11) + S_W'(in_data.m22);
    a_s_r[3]  <= ONE_S + S_W'(in_data.m00) + S_W'(in_data.m11) + S_W'(in_data.m22);
    a_sum01_r <= D_W'(in_data.m01) + D_W'(in_data.m10);
    a_sum02_r <= D_W'(in_data.m20) + D_W'(in_data.m02);
    a_sum12_r <= D_W'(in_data.m12) + D_W'(in_data.m21);
    a_dif12_r <= D_W'(in_data.m12) - D_W'(in_data.m21);
    a_dif20_r <= D_W'(in_data.m20) - D_W'(in_data.m02);
    a_dif01_r <= D_W'(in_data.m01) - D_W'(in_data.m10);
  end

  // Stage B: pick the largest sum (lower index wins ties), route numerators
  logic [1:0]            k01, k23, kk;
  logic [3:0][D_W-1:0]   d_sel;
  logic [1:0]            b_k_r;
  logic signed [S_W-1:0] b_sk_r;
  logic                  b_bad_r;
  logic [3:0][D_W-1:0]   b_d_r;

  always_comb begin
    k01   = (a_s_r[1] > a_s_r[0]) ? 2'd1 : 2'd0;
    k23   = (a_s_r[3] > a_s_r[2]) ? 2'd3 : 2'd2;
    kk    = (a_s_r[k23] > a_s_r[k01]) ? k23 : k01;
    d_sel = '0;
    case (kk)
      2'd0: begin
        d_sel[1] = a_sum01_r;
        d_sel[2] = a_sum02_r;
        d_sel[3] = a_dif12_r;
      end
      2'd1: begin
        d_sel[0] = a_sum01_r;
        d_sel[2] = a_sum12_r;
        d_sel[3] = a_dif20_r;
      end
      2'd2: begin
        d_sel[0] = a_sum02_r;
        d_sel[1] = a_sum12_r;
        d_sel[3] = a_dif01_r;
      end
      default: begin
        d_sel[0] = a_dif12_r;
        d_sel[1] = a_dif20_r;
        d_sel[2] = a_dif01_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    b_k_r   <= kk;
    b_sk_r  <= a_s_r[kk];
    b_bad_r <= (a_s_r[kk] <= 0);
    b_d_r   <= d_sel;
  end

  // Component root: floor(sqrt(s << (F-2))), one bit per stage
  rmq_pkg::sqs_t sq1_init;
  rmq_pkg::sqs_t sq1_r [C_W];
  side1_t        s1_r  [C_W];

  assign sq1_init.root = '0;
  assign sq1_init.rem  = SR_W'(b_sk_r[S_W-2:0]) << (F - 2);

  for (genvar j = 0; j < C_W; j++) begin : g_sq1
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq1_r[j] <= rmq_pkg::sqrt_step(sq1_init, C_W - 1 - j);
        s1_r[j]  <= '{k: b_k_r, bad: b_bad_r, d: b_d_r};
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        sq1_r[j] <= rmq_pkg::sqrt_step(sq1_r[j-1], C_W - 1 - j);
        s1_r[j]  <= s1_r[j-1];
      end
    end
  end

  // First divider bank: |d| * 2^F / (4c)
  logic [C_W-1:0] c1;
  logic [D_W-1:0] den1;
  logic [Q_W-1:0] q1 [4];
  side2_t         s2_r [DIV_LAT];

  assign c1   = sq1_r[C_W-1].root[C_W-1:0];
  assign den1 = {c1, 2'b00};

  for (genvar i = 0; i < 4; i++) begin : g_div1
    logic [D_W-1:0] dv, dmag;
    assign dv   = s1_r[C_W-1].d[i];
    assign dmag = dv[D_W-1] ? (~dv + D_W'(1)) : dv;
    rmq_div #(.N_W(D_W), .D_W(D_W)) u_div (
      .clk (clk),
      .num (dmag),
      .den (den1),
      .quo (q1[i])
    );
  end

  always_ff @(posedge clk) begin
    s2_r[0].c   <= c1;
    s2_r[0].k   <= s1_r[C_W-1].k;
    s2_r[0].bad <= s1_r[C_W-1].bad;
    for (int i = 0; i < 4; i++) begin
      s2_r[0].dneg[i] <= s1_r[C_W-1].d[i][D_W-1];
    end
    for (int i = 1; i < DIV_LAT; i++) begin
      s2_r[i] <= s2_r[i-1];
    end
  end

  // Stage D: signed components
  logic [3:0][P_W-1:0] p_r;
  logic                d_bad_r;

  always_ff @(posedge clk) begin
    d_bad_r <= s2_r[DIV_LAT-1].bad;
    for (int i = 0; i < 4; i++) begin
      if (s2_r[DIV_LAT-1].k == 2'(i)) begin
        p_r[i] <= P_W'(s2_r[DIV_LAT-1].c);
      end else if (s2_r[DIV_LAT-1].dneg[i]) begin
        p_r[i] <= -P_W'(q1[i]);
      end else begin
        p_r[i] <= P_W'(q1[i]);
      end
    end
  end

  // Stage E: partial products of each square
  logic [M_W-1:0]     e_mag [4];
  logic [2*H_W-1:0]   e_hh_r [4];
  logic [M_W-1:0]     e_hl_r [4];
  logic [2*L_W-1:0]   e_ll_r [4];
  pside_t             pd_r [PD_LEN];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e_mag[i] = p_r[i][P_W-1] ? M_W'(~p_r[i] + P_W'(1)) : p_r[i][M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      e_hh_r[i] <= e_mag[i][M_W-1:L_W] * e_mag[i][M_W-1:L_W];
      e_hl_r[i] <= e_mag[i][M_W-1:L_W] * e_mag[i][L_W-1:0];
      e_ll_r[i] <= e_mag[i][L_W-1:0] * e_mag[i][L_W-1:0];
    end
    pd_r[0] <= '{p: p_r, bad: d_bad_r};
    for (int i = 1; i < PD_LEN; i++) begin
      pd_r[i] <= pd_r[i-1];
    end
  end

  // Stages F-H: squares, pair sums, norm squared
  logic [SQ_W-1:0] f_sq_r [4];
  logic [SQ_W-1:0] g_pair_r [2];
  logic [SQ_W-1:0] h_sum_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      f_sq_r[i] <= (SQ_W'(e_hh_r[i]) << (2 * L_W)) + (SQ_W'(e_hl_r[i]) << (L_W + 1))
                   + SQ_W'(e_ll_r[i]);
    end
    g_pair_r[0] <= f_sq_r[0] + f_sq_r[1];
    g_pair_r[1] <= f_sq_r[2] + f_sq_r[3];
    h_sum_r     <= g_pair_r[0] + g_pair_r[1];
  end

  // Norm root, one bit per stage
  rmq_pkg::sqs_t sq2_init;
  rmq_pkg::sqs_t sq2_r [RT_W];

  assign sq2_init.root = '0;
  assign sq2_init.rem  = SR_W'(h_sum_r);

  for (genvar j = 0; j < RT_W; j++) begin : g_sq2
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        sq2_r[j] <= rmq_pkg::sqrt_step(sq2_init, RT_W - 1 - j);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        sq2_r[j] <= rmq_pkg::sqrt_step(sq2_r[j-1], RT_W - 1 - j);
      end
    end
  end

  // Norm check and second divider bank: |p| * 2^F / norm
  logic [RT_W-1:0] nrm, dev;
  logic            p3neg, renorm_i;
  logic [Q_W-1:0]  q2 [4];
  side4_t          s4_r [DIV_LAT];

  assign nrm      = sq2_r[RT_W-1].root;
  assign dev      = (nrm > ONE_N) ? (nrm - ONE_N) : (ONE_N - nrm);
  assign p3neg    = pd_r[PD_LEN-1].p[3][P_W-1];
  assign renorm_i = p3neg || (dev > RT_W'(tol_r));

  for (genvar i = 0; i < 4; i++) begin : g_div2
    logic [P_W-1:0] pv;
    logic [M_W-1:0] pmag;
    assign pv   = pd_r[PD_LEN-1].p[i];
    assign pmag = pv[P_W-1] ? M_W'(~pv + P_W'(1)) : pv[M_W-1:0];
    rmq_div #(.N_W(M_W), .D_W(RT_W)) u_div (
      .clk (clk),
      .num (pmag),
      .den (nrm),
      .quo (q2[i])
    );
  end

  always_ff @(posedge clk) begin
    s4_r[0] <= '{p: pd_r[PD_LEN-1].p, renorm: renorm_i, flip: p3neg,
                 bad: pd_r[PD_LEN-1].bad};
    for (int i = 1; i < DIV_LAT; i++) begin
      s4_r[i] <= s4_r[i-1];
    end
  end

  // Output stage: sign, saturation, bad-matrix override
  logic signed [V_W-1:0] ov [4];
  logic [3:0][31:0]      oq;
  rmq_pkg::out_beat_t    out_nxt;
  rmq_pkg::out_beat_t    out_data_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s4_r[DIV_LAT-1].renorm) begin
        if (s4_r[DIV_LAT-1].p[i][P_W-1] ^ s4_r[DIV_LAT-1].flip) begin
          ov[i] = -V_W'(q2[i]);
        end else begin
          ov[i] = V_W'(q2[i]);
        end
      end else begin
        ov[i] = {s4_r[DIV_LAT-1].p[i][P_W-1], s4_r[DIV_LAT-1].p[i]};
      end
      if (ov[i] > MAXV) begin
        oq[i] = 32'h7fffffff;
      end else if (ov[i] < MINV) begin
        oq[i] = 32'h80000000;
      end else begin
        oq[i] = ov[i][31:0];
      end
    end
    if (s4_r[DIV_LAT-1].bad) begin
      out_nxt = '0;
      out_nxt.bad_matrix = 1'b1;
    end else begin
      out_nxt.quat_x       = oq[0];
      out_nxt.quat_y       = oq[1];
      out_nxt.quat_z       = oq[2];
      out_nxt.quat_w       = oq[3];
      out_nxt.renormalized = s4_r[DIV_LAT-1].renorm;
      out_nxt.bad_matrix   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_data   = out_data_r;
  assign out_strobe = vld_r[LAT-1];

  // Every accepted beat produces a result on out_strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted beat did not produce a result at the expected cycle");

  // Scalar part is never negative on a delivered result
  a_w_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !out_data.quat_w[31])
    else $error("negative scalar part on output");

  // A bad matrix gives all zeros and no renormalize flag
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.bad_matrix) |->
      (!out_data.renormalized && out_data.quat_x == 0 && out_data.quat_y == 0 &&
       out_data.quat_z == 0 && out_data.quat_w == 0))
    else $error("bad matrix result not cleared");

endmodule

### hw/rtl/rmq_div.sv
// Pipelined restoring divider: clamp(floor(num * 2^FRAC_BITS / den)), one bit per stage.
module rmq_div #(
  parameter int N_W = rmq_pkg::RT_W,
  parameter int D_W = rmq_pkg::RT_W
) (
  input  logic                   clk,
  input  logic [N_W-1:0]         num,
  input  logic [D_W-1:0]         den,
  output logic [rmq_pkg::Q_W-1:0] quo
);

  localparam int Q_W = rmq_pkg::Q_W;
  localparam int F   = rmq_pkg::FRAC_BITS;
  localparam int W   = ((N_W + F > D_W + Q_W) ? N_W + F : D_W + Q_W) + 1;
  localparam logic [Q_W-1:0] LIMIT = Q_W'(1) << (Q_W - 1);

  logic [W-1:0]   rem_r [Q_W];
  logic [D_W-1:0] dd_r  [Q_W];
  logic [Q_W-1:0] q_r   [Q_W+1];
  logic [Q_W:0]   ovf_r;

  // Entry: scaled numerator, quotient overflow check
  always_ff @(posedge clk) begin
    rem_r[0] <= W'(num) << F;
    dd_r[0]  <= den;
    q_r[0]   <= '0;
    ovf_r[0] <= (W'(num) << F) >= (W'(den) << Q_W);
  end

  // One quotient bit per stage, MSB first
  for (genvar j = 1; j <= Q_W; j++) begin : g_bit
    logic [W-1:0] trial;
    logic         take;
    assign trial = W'(dd_r[j-1]) << (Q_W - j);
    assign take  = rem_r[j-1] >= trial;

    always_ff @(posedge clk) begin
      q_r[j]   <= take ? (q_r[j-1] | (Q_W'(1) << (Q_W - j))) : q_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
    end

    if (j < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[j] <= take ? (rem_r[j-1] - trial) : rem_r[j-1];
        dd_r[j]  <= dd_r[j-1];
      end
    end
  end

  assign quo = (ovf_r[Q_W] || (q_r[Q_W] > LIMIT)) ? LIMIT : q_r[Q_W];

endmodule

### sim/tb_top.sv
// Self-checking testbench for the matrix-to-quaternion converter.
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 165;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  rmq_pkg::in_beat_t           in_data;
  logic                        out_strobe;
  rmq_pkg::out_beat_t          out_data;
  logic                        cfg_we;
  logic [rmq_pkg::TOL_W-1:0]   cfg_wdata;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the tolerance register
  logic [rmq_pkg::TOL_W-1:0] tol_model;
  rmq_pkg::out_beat_t        quat_queue[$];
  int                        err_count;
  int                        beats_sent;
  int                        beats_seen;
  int                        renorm_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // (v << FRAC_BITS) / d toward zero, magnitude clamped at 2^40
  function automatic logic signed [63:0] frac_div(input logic signed [63:0] v,
                                                  input logic [63:0] d);
    logic [127:0] num;
    logic [127:0] q;
    logic [63:0]  m;
    m = v[63] ? -v : v;
    num = {64'd0, m} << rmq_pkg::FRAC_BITS;
    if (d == 0 || num[127:64] >= d) q = {64'd0, {64{1'b1}}};
    else q = num / d;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return v[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic rmq_pkg::out_beat_t predict_quat(input rmq_pkg::in_beat_t m);
    logic signed [63:0] one, s[4], dv[4], p[4];
    logic [63:0]        c, den, nrm, dev;
    logic [127:0]       sq;
    int                 k;
    logic               flip;
    rmq_pkg::out_beat_t r;
    one = 64'sd1 <<< rmq_pkg::FRAC_BITS;
    s[0] = one + m.m00 - m.m11 - m.m22;
    s[1] = one - m.m00 + m.m11 - m.m22;
    s[2] = one - m.m00 - m.m11 + m.m22;
    s[3] = one + m.m00 + m.m11 + m.m22;
    k = 0;
    for (int i = 1; i < 4; i++) if (s[i] > s[k]) k = i;
    r = '0;
    if (s[k] <= 0) begin
      r.bad_matrix = 1'b1;
      return r;
    end
    c = 64'(isqrt({64'd0, s[k]} << (rmq_pkg::FRAC_BITS - 2)));
    den = c << 2;
    dv = '{default: 64'sd0};
    case (k)
      0: begin
        dv[1] = m.m01 + m.m10; dv[2] = m.m20 + m.m02; dv[3] = m.m12 - m.m21;
      end
      1: begin
        dv[0] = m.m01 + m.m10; dv[2] = m.m12 + m.m21; dv[3] = m.m20 - m.m02;
      end
      2: begin
        dv[0] = m.m20 + m.m02; dv[1] = m.m12 + m.m21; dv[3] = m.m01 - m.m10;
      end
      default: begin
        dv[0] = m.m12 - m.m21; dv[1] = m.m20 - m.m02; dv[2] = m.m01 - m.m10;
      end
    endcase
    for (int i = 0; i < 4; i++) p[i] = (i == k) ? $signed(c) : frac_div(dv[i], den);
    sq = '0;
    for (int i = 0; i < 4; i++) begin
      c = p[i][63] ? -p[i] : p[i];
      sq = sq + {64'd0, c} * {64'd0, c};
    end
    nrm = 64'(isqrt(sq));
    dev = (nrm > one) ? nrm - one : one - nrm;
    flip = p[3] < 0;
    r.renormalized = flip ||
                     (({64'd0, dev} << 30) > ({98'd0, tol_model} << rmq_pkg::FRAC_BITS));
    if (r.renormalized)
      for (int i = 0; i < 4; i++) begin
        p[i] = frac_div(p[i], nrm);
        if (flip) p[i] = -p[i];
      end
    r.quat_x = clamp32(p[0]);
    r.quat_y = clamp32(p[1]);
    r.quat_z = clamp32(p[2]);
    r.quat_w = clamp32(p[3]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    $display("MISMATCH beat %0d %s: got %h want %h", beats_seen, what, got, want);
  endtask

  // Result checker
  always @(posedge clk) begin
    rmq_pkg::out_beat_t w;
    if (rst_n && out_strobe) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        w = quat_queue.pop_front();
        if (out_data.quat_x !== w.quat_x) report_mismatch("quat_x", out_data.quat_x, w.quat_x);
        if (out_data.quat_y !== w.quat_y) report_mismatch("quat_y", out_data.quat_y, w.quat_y);
        if (out_data.quat_z !== w.quat_z) report_mismatch("quat_z", out_data.quat_z, w.quat_z);
        if (out_data.quat_w !== w.quat_w) report_mismatch("quat_w", out_data.quat_w, w.quat_w);
        if (out_data.renormalized !== w.renormalized)
          report_mismatch("renormalized", 32'(out_data.renormalized), 32'(w.renormalized));
        if (out_data.bad_matrix !== w.bad_matrix)
          report_mismatch("bad_matrix", 32'(out_data.bad_matrix), 32'(w.bad_matrix));
        if (out_data.renormalized) renorm_seen++;
      end
      beats_seen++;
    end
  end

  // Random idle time; start drops only when the gap is not empty
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drive one beat, held until accepted; start drops only if a gap follows
  task automatic send_matrix(input rmq_pkg::in_beat_t m, input logic gaps);
    start   <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    quat_queue.push_back(predict_quat(m));
    beats_sent++;
    if (gaps) begin
      idle_gap();
    end
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk);
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_tol(input logic [rmq_pkg::TOL_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_model = v;
  endtask

  function automatic logic signed [31:0] q30(input real v);
    return $rtoi(v * 1073741824.0);
  endfunction

  // Near-rotation matrix built from a random unit quaternion
  function automatic rmq_pkg::in_beat_t rand_rotation();
    real a, b, c, d, n;
    rmq_pkg::in_beat_t m;
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d) + 0.001;
    a /= n; b /= n; c /= n; d /= n;
    m.m00 = q30(1 - 2 * (b * b + c * c));
    m.m01 = q30(2 * (a * b - c * d));
    m.m02 = q30(2 * (a * c + b * d));
    m.m10 = q30(2 * (a * b + c * d));
    m.m11 = q30(1 - 2 * (a * a + c * c));
    m.m12 = q30(2 * (b * c - a * d));
    m.m20 = q30(2 * (a * c - b * d));
    m.m21 = q30(2 * (b * c + a * d));
    m.m22 = q30(1 - 2 * (a * a + b * b));
    if ($urandom_range(0, 3) == 0) m.m01 = m.m01 + $signed($urandom_range(0, 4096) - 2048);
    return m;
  endfunction

  function automatic rmq_pkg::in_beat_t rand_noise();
    rmq_pkg::in_beat_t m;
    m = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    return m;
  endfunction

  // Directed rows; expected value typed in only for identity
  typedef struct {
    rmq_pkg::in_beat_t  m;
    logic               has_want;
    rmq_pkg::out_beat_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];
  localparam logic signed [31:0] ONE = 32'sh40000000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  initial begin
    dir_row_t r;
    rmq_pkg::out_beat_t w;
    rst_n = 1'b0; start = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_wdata = '0;
    tol_model = rmq_pkg::TOL_RESET;
    err_count = 0; beats_sent = 0; beats_seen = 0; renorm_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity: w = 1, rest 0
    r.m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; r.has_want = 1'b1;
    r.want = '{0, 0, 0, ONE, 1'b0, 1'b0}; dir_rows.push_back(r);
    r.has_want = 1'b0;
    // 180 degree turns pick x, y, z branches
    r.m = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; dir_rows.push_back(r);
    r.m = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; dir_rows.push_back(r);
    r.m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; dir_rows.push_back(r);
    // Ties between sums, lowest index wins
    r.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; dir_rows.push_back(r);
    r.m = '{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE}; dir_rows.push_back(r);
    // Scalar part of either sign; a negative one forces a sign flip
    r.m = '{ONE, 0, 0, 0, -ONE, 32'sh1000, 0, -32'sh1000, -ONE}; dir_rows.push_back(r);
    r.m = '{-ONE, 0, 32'sh2000, 0, ONE, 0, -32'sh2000, 0, -ONE}; dir_rows.push_back(r);
    // Extremes of the fields
    r.m = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; dir_rows.push_back(r);
    r.m = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; dir_rows.push_back(r);
    r.m = '{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV}; dir_rows.push_back(r);
    r.m = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV}; dir_rows.push_back(r);
    r.m = '{-ONE, MAXV, MINV, MINV, -ONE, MAXV, MAXV, MINV, -ONE}; dir_rows.push_back(r);
    r.m = '{-32'sh3fffffff, 0, 0, 0, -32'sh3fffffff, 0, 0, 0, -32'sh3fffffff};
    dir_rows.push_back(r);
    r.m = '{ONE, -1, 1, 1, ONE, -1, -1, 1, ONE}; dir_rows.push_back(r);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_want) begin
        w = predict_quat(dir_rows[i].m);
        if (w !== dir_rows[i].want) report_mismatch("directed predictor", w.quat_w, 0);
      end
      send_matrix(dir_rows[i].m, 1'b1);
    end
    drain_pipe();

    // Sweep tolerance through extremes and random values
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_tol('0);
        1: write_tol({rmq_pkg::TOL_W{1'b1}});
        2: write_tol(rmq_pkg::TOL_RESET);
        3: write_tol(rmq_pkg::TOL_W'($urandom_range(0, 2000)));
        4: write_tol(rmq_pkg::TOL_W'($urandom()));
        default: write_tol(rmq_pkg::TOL_W'(1) << rmq_pkg::TOL_W - 1);
      endcase
      for (int i = 0; i < 90; i++) begin
        if ($urandom_range(0, 4) == 0) send_matrix(rand_noise(), 1'($urandom_range(0, 1)));
        else send_matrix(rand_rotation(),
                         (ph % 2 == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
      end
      // sender holds off until all results are back
      drain_pipe();
    end

    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d matrices (directed and random) over six tolerance settings,", beats_sent);
    $display("received %0d quaternions, %0d renormalized.", beats_seen, renorm_seen);
    if (err_count == 0 && quat_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### rotation_matrix_to_quaternion.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
sim/tb_top.sv
